// ===== hw/rtl/dpcd_pkg.sv =====
// Shared types, codes and decode constants for the pushbuffer command decoder.
package dpcd_pkg;

    // Field widths
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned METHOD_W = 13;
    localparam int unsigned SUBCH_W  = 3;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned FAULT_W  = 3;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PUSH_ENABLE  = 1'd1;

    // Request opcodes
    localparam logic OP_WORD    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Header decode masks and patterns
    localparam logic [WORD_W-1:0] OLD_JUMP_MASK  = 32'he000_0003;
    localparam logic [WORD_W-1:0] OLD_JUMP_CODE  = 32'h2000_0000;
    localparam logic [WORD_W-1:0] OLD_JUMP_ADDR  = 32'h1fff_ffff;
    localparam logic [WORD_W-1:0] WORD_ADDR_MASK = 32'hffff_fffc;
    localparam logic [WORD_W-1:0] RETURN_WORD    = 32'h0002_0000;
    localparam logic [WORD_W-1:0] METHOD_MASK    = 32'he003_0003;
    localparam logic [WORD_W-1:0] INC_CODE       = 32'h0000_0000;
    localparam logic [WORD_W-1:0] NONINC_CODE    = 32'h4000_0000;
    localparam logic [1:0]        TYPE_JUMP      = 2'd1;
    localparam logic [1:0]        TYPE_CALL      = 2'd2;

    localparam logic [ADDR_W-1:0]   WORD_BYTES  = 32'd4;
    localparam logic [METHOD_W-1:0] METHOD_STEP = 13'd4;

    // Fault codes
    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE        = 3'd0,
        FAULT_CALL_NESTED = 3'd1,
        FAULT_RETURN_BARE = 3'd2,
        FAULT_RESERVED    = 3'd3,
        FAULT_PROTECTION  = 3'd4
    } t_fault;

    typedef struct packed {
        logic [ADDR_W-1:0] buffer_limit;
        logic              push_enable;
    } t_cfg;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] data_word;
        logic [ADDR_W-1:0] restart_address;
        logic [ADDR_W-1:0] put_pointer;
    } t_item;

    typedef struct packed {
        logic                cmd_valid;
        logic [METHOD_W-1:0] cmd_method;
        logic [SUBCH_W-1:0]  cmd_subchannel;
        logic                cmd_nonincreasing;
        logic [WORD_W-1:0]   cmd_parameter;
        logic [ADDR_W-1:0]   next_get;
        logic                caught_up;
        logic [FAULT_W-1:0]  fault_code;
        logic                irq_pulse;
    } t_result;

endpackage

// ===== hw/rtl/dpcd_cfg_regs.sv =====
// Configuration registers: buffer limit and push enable.
module dpcd_cfg_regs
    import dpcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [ADDR_W-1:0] r_buffer_limit;
    logic              r_push_enable;

    // Latch a write into the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_limit <= '0;
            r_push_enable  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BUFFER_LIMIT: r_buffer_limit <= i_cfg_data[ADDR_W-1:0];
                CFG_PUSH_ENABLE:  r_push_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg.buffer_limit = r_buffer_limit;
    assign o_cfg.push_enable  = r_push_enable;

endmodule

// ===== hw/rtl/dpcd_decode.sv =====
// Channel state and combinational decode of one pushbuffer request.
module dpcd_decode
    import dpcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_advance,
    input  t_item   i_item,
    output t_result o_result
);

    logic [ADDR_W-1:0]   r_read_pointer,   n_read_pointer;
    logic [ADDR_W-1:0]   r_return_address, n_return_address;
    logic                r_in_subroutine,  n_in_subroutine;
    logic [METHOD_W-1:0] r_method,         n_method;
    logic [SUBCH_W-1:0]  r_subchannel,     n_subchannel;
    logic [COUNT_W-1:0]  r_words_left,     n_words_left;
    logic                r_fixed_method,   n_fixed_method;
    t_fault              r_fault,          n_fault;
    logic                r_halted,         n_halted;

    t_fault              new_fault;
    logic [ADDR_W-1:0]   rp_next;
    logic [WORD_W-1:0]   w;
    t_result             res;

    assign w       = i_item.data_word;
    assign rp_next = r_read_pointer + WORD_BYTES;

    // Work out next state and the result for the current request
    always_comb begin
        n_read_pointer   = r_read_pointer;
        n_return_address = r_return_address;
        n_in_subroutine  = r_in_subroutine;
        n_method         = r_method;
        n_subchannel     = r_subchannel;
        n_words_left     = r_words_left;
        n_fixed_method   = r_fixed_method;
        n_fault          = r_fault;
        n_halted         = r_halted;
        new_fault        = FAULT_NONE;
        res              = '0;

        if (i_item.op == OP_RESTART) begin
            n_read_pointer = i_item.restart_address;
            n_fault        = FAULT_NONE;
            n_halted       = 1'b0;
        end else if (i_cfg.push_enable && !r_halted
                     && (r_read_pointer != i_item.put_pointer)) begin
            if (r_read_pointer >= i_cfg.buffer_limit) begin
                new_fault = FAULT_PROTECTION;
            end else begin
                n_read_pointer = rp_next;
                if (r_words_left != '0) begin
                    // Emit a method command from the pending count
                    res.cmd_valid         = 1'b1;
                    res.cmd_method        = r_method;
                    res.cmd_subchannel    = r_subchannel;
                    res.cmd_nonincreasing = r_fixed_method;
                    res.cmd_parameter     = w;
                    if (!r_fixed_method) begin
                        n_method = r_method + METHOD_STEP;
                    end
                    n_words_left = r_words_left - COUNT_W'(1);
                end else begin
                    // Decode a header word
                    priority if ((w & OLD_JUMP_MASK) == OLD_JUMP_CODE) begin
                        n_read_pointer = w & OLD_JUMP_ADDR;
                    end else if (w[1:0] == TYPE_JUMP) begin
                        n_read_pointer = w & WORD_ADDR_MASK;
                    end else if (w[1:0] == TYPE_CALL) begin
                        if (r_in_subroutine) begin
                            new_fault = FAULT_CALL_NESTED;
                        end else begin
                            n_return_address = rp_next;
                            n_in_subroutine  = 1'b1;
                            n_read_pointer   = w & WORD_ADDR_MASK;
                        end
                    end else if (w == RETURN_WORD) begin
                        if (!r_in_subroutine) begin
                            new_fault = FAULT_RETURN_BARE;
                        end else begin
                            n_read_pointer  = r_return_address;
                            n_in_subroutine = 1'b0;
                        end
                    end else if ((w & METHOD_MASK) == INC_CODE) begin
                        n_method       = w[METHOD_W-1:0];
                        n_subchannel   = w[15:13];
                        n_words_left   = w[28:18];
                        n_fixed_method = 1'b0;
                    end else if ((w & METHOD_MASK) == NONINC_CODE) begin
                        n_method       = w[METHOD_W-1:0];
                        n_subchannel   = w[15:13];
                        n_words_left   = w[28:18];
                        n_fixed_method = 1'b1;
                    end else begin
                        new_fault = FAULT_RESERVED;
                    end
                end
            end
            // Halt and raise the interrupt on any fault
            if (new_fault != FAULT_NONE) begin
                n_fault       = new_fault;
                n_halted      = 1'b1;
                res.irq_pulse = 1'b1;
            end
        end

        res.next_get   = n_read_pointer;
        res.caught_up  = (n_read_pointer == i_item.put_pointer);
        res.fault_code = n_fault;
    end

    // Commit state when the request moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_pointer   <= '0;
            r_return_address <= '0;
            r_in_subroutine  <= 1'b0;
            r_method         <= '0;
            r_subchannel     <= '0;
            r_words_left     <= '0;
            r_fixed_method   <= 1'b0;
            r_fault          <= FAULT_NONE;
            r_halted         <= 1'b0;
        end else if (i_advance) begin
            r_read_pointer   <= n_read_pointer;
            r_return_address <= n_return_address;
            r_in_subroutine  <= n_in_subroutine;
            r_method         <= n_method;
            r_subchannel     <= n_subchannel;
            r_words_left     <= n_words_left;
            r_fixed_method   <= n_fixed_method;
            r_fault          <= n_fault;
            r_halted         <= n_halted;
        end
    end

    assign o_result = res;

endmodule

// ===== hw/rtl/dma_pushbuffer_command_decoder.sv =====
// Top level of the pushbuffer command decoder: request register, decode, result register.
//
//   Channel  Direction  Handshake             Payload
//   request  in         i_valid / o_stall     op, data_word, restart_address, put_pointer
//   result   out        o_valid / i_stall     cmd_*, next_get, caught_up, fault_code, irq_pulse
//   config   in         i_cfg_we              i_cfg_index, i_cfg_data
//
// One request per cycle unless the result stalls; each passes the request, then the result register.
// The decode and all channel state update in the cycle a request leaves the
// request register, so consecutive words decode back to back.
// Reset (synchronous, active low) clears channel state, config and both valids.
// A stalled result holds the request register; o_stall rises only when both are full.
module dma_pushbuffer_command_decoder
    import dpcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_op,
    input  logic [WORD_W-1:0]     i_data_word,
    input  logic [ADDR_W-1:0]     i_restart_address,
    input  logic [ADDR_W-1:0]     i_put_pointer,

    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_cmd_valid,
    output logic [METHOD_W-1:0]   o_cmd_method,
    output logic [SUBCH_W-1:0]    o_cmd_subchannel,
    output logic                  o_cmd_nonincreasing,
    output logic [WORD_W-1:0]     o_cmd_parameter,
    output logic [ADDR_W-1:0]     o_next_get,
    output logic                  o_caught_up,
    output logic [FAULT_W-1:0]    o_fault_code,
    output logic                  o_irq_pulse
);

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result result;
    logic    advance;
    logic    accept;

    dpcd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Move the held request into decode when the result slot is free or being taken
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    dpcd_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_item    (r_item),
        .o_result  (result)
    );

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op              <= i_op;
            r_item.data_word       <= i_data_word;
            r_item.restart_address <= i_restart_address;
            r_item.put_pointer     <= i_put_pointer;
        end
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_cmd_valid         = r_out.cmd_valid;
    assign o_cmd_method        = r_out.cmd_method;
    assign o_cmd_subchannel    = r_out.cmd_subchannel;
    assign o_cmd_nonincreasing = r_out.cmd_nonincreasing;
    assign o_cmd_parameter     = r_out.cmd_parameter;
    assign o_next_get          = r_out.next_get;
    assign o_caught_up         = r_out.caught_up;
    assign o_fault_code        = r_out.fault_code;
    assign o_irq_pulse         = r_out.irq_pulse;

endmodule
